// ===== design/clr_pkg.sv =====
// shared constants, codes and line state type for the clipped line rasteriser
package clr_pkg;

   // coordinate width of all points, endpoints and clip bounds
   localparam int CoordBits = 16;
   localparam int CsrIndexBits = 3;
   localparam int ColorBits = 8;

   typedef logic signed [CoordBits-1:0] coord_type;

   // reset value of the exclusive clip bounds: largest positive coordinate
   localparam coord_type ClipMax = {1'b0, {(CoordBits-1){1'b1}}};

   // input commands
   typedef enum logic {
      CmdStart   = 1'b0,
      CmdAdvance = 1'b1
   } command_type;

   // configuration register indexes
   localparam logic [CsrIndexBits-1:0] CsrClipLeft   = CsrIndexBits'(0);
   localparam logic [CsrIndexBits-1:0] CsrClipTop    = CsrIndexBits'(1);
   localparam logic [CsrIndexBits-1:0] CsrClipRight  = CsrIndexBits'(2);
   localparam logic [CsrIndexBits-1:0] CsrClipBottom = CsrIndexBits'(3);

   // bresenham walker state
   typedef struct packed {
      coord_type                   cursor_x;
      coord_type                   cursor_y;
      coord_type                   target_x;
      coord_type                   target_y;
      logic        [CoordBits:0]   span_x;
      logic signed [CoordBits+1:0] span_y;
      logic                        step_x_neg;
      logic                        step_y_neg;
      logic signed [CoordBits+2:0] error_term;
   } line_state_type;

endpackage

// ===== design/clr_advance.sv =====
// one bresenham step: next cursor and error term, and the end-of-line decision
module clr_advance (
   input  clr_pkg::line_state_type cur_state,
   output clr_pkg::line_state_type next_state,
   output logic                    line_done
);
   import clr_pkg::*;

   logic                        at_x;
   logic                        at_y;
   logic                        x_cond;
   logic                        y_cond;
   logic                        x_move;
   logic                        y_move;
   logic signed [CoordBits+3:0] err_ext;
   logic signed [CoordBits+3:0] err_double;
   logic signed [CoordBits+3:0] span_x_ext;
   logic signed [CoordBits+3:0] span_y_ext;
   logic signed [CoordBits+3:0] err_sum;

   // sign and zero extension onto a common width
   assign err_ext    = $signed({cur_state.error_term[CoordBits+2], cur_state.error_term});
   assign err_double = $signed({cur_state.error_term, 1'b0});
   assign span_x_ext = $signed({3'b000, cur_state.span_x});
   assign span_y_ext = $signed({{2{cur_state.span_y[CoordBits+1]}}, cur_state.span_y});

   // axis decisions from the doubled error
   assign at_x   = (cur_state.cursor_x == cur_state.target_x);
   assign at_y   = (cur_state.cursor_y == cur_state.target_y);
   assign x_cond = (err_double >= span_y_ext);
   assign y_cond = (err_double <= span_x_ext);
   assign x_move = x_cond && !at_x;
   assign y_move = y_cond && !at_y;

   // line ends on the target or on a reached axis that still wants a step
   assign line_done = (at_x && at_y) || (x_cond && at_x) || (y_cond && at_y);

   assign err_sum = err_ext + (x_move ? span_y_ext : '0) + (y_move ? span_x_ext : '0);

   // next walker state
   always_comb begin
      next_state            = cur_state;
      next_state.error_term = err_sum[CoordBits+2:0];
      if (x_move) begin
         next_state.cursor_x = cur_state.step_x_neg ? cur_state.cursor_x - CoordBits'(1)
                                                    : cur_state.cursor_x + CoordBits'(1);
      end
      if (y_move) begin
         next_state.cursor_y = cur_state.step_y_neg ? cur_state.cursor_y - CoordBits'(1)
                                                    : cur_state.cursor_y + CoordBits'(1);
      end
   end

endmodule

// ===== design/clipped_line_rasterizer_unit.sv =====
// clipped line rasteriser: command decode, line state, clip test and result register
//
// Request channel (req_): a start command loads two signed endpoints and a
// colour tag and at once yields the first point; an advance command yields the
// next point of the active line. An advance with no active line yields nothing.
// Response channel (rsp_): one point per transfer with its coordinates, colour,
// clip flag (inside_res) and a last flag on the final point of the line.
// Configuration (csr_): clip rectangle bounds, to be written by the user only
// while the block is idle, which the block does not enforce; right and bottom
// bounds are exclusive. A point is registered and appears on rsp_ the cycle
// after its request transfer. Throughput is one item per cycle unless rsp_
// stalls; the walker state updates at the request transfer, so advances may follow each other on every clock.
// A single result register decouples the sides: a request is taken when that
// register is empty or is being emptied in the same cycle, so a stalled
// response holds its point and stalls the request side.
// Synchronous reset clears the line (no line active), empties the result
// register and sets the clip rectangle to left/top 0, right/bottom at the
// largest positive coordinate.
module clipped_line_rasterizer_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration port
   input  logic                                    csr_write_enable,
   input  logic [clr_pkg::CsrIndexBits-1:0]        csr_index,
   input  logic [clr_pkg::CoordBits-1:0]           csr_write_data,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_command,
   input  logic signed [clr_pkg::CoordBits-1:0]    req_start_x,
   input  logic signed [clr_pkg::CoordBits-1:0]    req_start_y,
   input  logic signed [clr_pkg::CoordBits-1:0]    req_end_x,
   input  logic signed [clr_pkg::CoordBits-1:0]    req_end_y,
   input  logic [clr_pkg::ColorBits-1:0]           req_color_tag,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [clr_pkg::CoordBits-1:0]    rsp_pixel_x,
   output logic signed [clr_pkg::CoordBits-1:0]    rsp_pixel_y,
   output logic [clr_pkg::ColorBits-1:0]           rsp_pixel_color,
   output logic                                    rsp_inside_res,
   output logic                                    rsp_last
);
   import clr_pkg::*;

   // clip registers
   coord_type clip_left_ff;
   coord_type clip_top_ff;
   coord_type clip_right_ff;
   coord_type clip_bottom_ff;

   // line registers
   line_state_type        line_ff;
   line_state_type        line_in;
   logic                  line_active_ff;
   logic                  line_active_in;
   logic [ColorBits-1:0]  held_color_ff;

   // result register
   logic                  rsp_valid_ff;
   coord_type             rsp_pixel_x_ff;
   coord_type             rsp_pixel_y_ff;
   logic [ColorBits-1:0]  rsp_pixel_color_ff;
   logic                  rsp_inside_res_ff;
   logic                  rsp_last_ff;

   // combinational
   logic                        req_xfer;
   logic                        rsp_xfer;
   logic                        is_start;
   logic                        emit_point;
   logic signed [CoordBits:0]   delta_x;
   logic signed [CoordBits:0]   delta_y;
   logic [CoordBits:0]          abs_dx;
   logic [CoordBits:0]          abs_dy;
   line_state_type              start_state;
   line_state_type              cur_state;
   line_state_type              stepped_state;
   logic                        line_done;
   logic [ColorBits-1:0]        emit_color;
   logic                        point_inside;

   // handshakes
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_xfer   = req_valid && !req_stall;
   assign rsp_xfer   = rsp_valid_ff && !rsp_stall;
   assign is_start   = (req_command == CmdStart);
   assign emit_point = req_xfer && (is_start || line_active_ff);

   // line setup from the endpoints
   assign delta_x = $signed({req_end_x[CoordBits-1], req_end_x})
                  - $signed({req_start_x[CoordBits-1], req_start_x});
   assign delta_y = $signed({req_end_y[CoordBits-1], req_end_y})
                  - $signed({req_start_y[CoordBits-1], req_start_y});
   assign abs_dx  = delta_x[CoordBits] ? $unsigned(-delta_x) : $unsigned(delta_x);
   assign abs_dy  = delta_y[CoordBits] ? $unsigned(-delta_y) : $unsigned(delta_y);

   always_comb begin
      start_state.cursor_x   = req_start_x;
      start_state.cursor_y   = req_start_y;
      start_state.target_x   = req_end_x;
      start_state.target_y   = req_end_y;
      start_state.span_x     = abs_dx;
      start_state.span_y     = -$signed({1'b0, abs_dy});
      start_state.step_x_neg = !(req_start_x < req_end_x);
      start_state.step_y_neg = !(req_start_y < req_end_y);
      start_state.error_term = $signed({2'b00, abs_dx}) - $signed({2'b00, abs_dy});
   end

   // point being emitted now
   assign cur_state  = is_start ? start_state : line_ff;
   assign emit_color = is_start ? req_color_tag : held_color_ff;

   assign point_inside = (cur_state.cursor_x >= clip_left_ff)
                      && (cur_state.cursor_x <  clip_right_ff)
                      && (cur_state.cursor_y >= clip_top_ff)
                      && (cur_state.cursor_y <  clip_bottom_ff);

   clr_advance u_advance (
      .cur_state  (cur_state),
      .next_state (stepped_state),
      .line_done  (line_done)
   );

   // next line state
   always_comb begin
      line_in        = line_ff;
      line_active_in = line_active_ff;
      if (emit_point) begin
         line_in        = stepped_state;
         line_active_in = !line_done;
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      if (emit_point && is_start) begin
         held_color_ff <= req_color_tag;
      end
   end

   // clip rectangle writes
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_right_ff  <= ClipMax;
         clip_bottom_ff <= ClipMax;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrClipLeft:   clip_left_ff   <= csr_write_data;
            CsrClipTop:    clip_top_ff    <= csr_write_data;
            CsrClipRight:  clip_right_ff  <= csr_write_data;
            CsrClipBottom: clip_bottom_ff <= csr_write_data;
            default:       ;
         endcase
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_point) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (emit_point) begin
         rsp_pixel_x_ff     <= cur_state.cursor_x;
         rsp_pixel_y_ff     <= cur_state.cursor_y;
         rsp_pixel_color_ff <= emit_color;
         rsp_inside_res_ff  <= point_inside;
         rsp_last_ff        <= line_done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_pixel_x_ff;
   assign rsp_pixel_y     = rsp_pixel_y_ff;
   assign rsp_pixel_color = rsp_pixel_color_ff;
   assign rsp_inside_res  = rsp_inside_res_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // an advance with no active line leaves the result register empty
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !is_start && !line_active_ff) |=> !rsp_valid_ff)
      else $error("advance without active line produced a point");

   // a start shows its start point on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_start) |=> (rsp_valid_ff
         && rsp_pixel_x_ff == $past(req_start_x)
         && rsp_pixel_y_ff == $past(req_start_y)))
      else $error("start point not presented");

   // once the last point leaves, the line is over unless a new one starts
   assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_last_ff && !(req_xfer && is_start)) |=> !line_active_ff)
      else $error("line still active after last point");

   // a line only becomes active through a start transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(line_active_ff) |-> $past(req_xfer && is_start))
      else $error("line activated without start");
`endif

endmodule

// ===== verif/clipped_line_rasterizer_unit_test.sv =====
// self-checking testbench for the clipped line rasteriser with its own bresenham walker
module clipped_line_rasterizer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import clr_pkg::*;

   localparam int ClockPeriod = 10;
   localparam int ResetCycles = 6;
   localparam int SettleCycles = 4;
   localparam int HoldOffCycles = 400;
   localparam int RandomPoints = 450;
   localparam int ReclipPoints = 110;
   localparam int ClipLines = 10;
   localparam int CycleLimit = 1000000;
   localparam int ErrBits = CoordBits + 3;
   localparam coord_type CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

   // one request as offered on the req_ side
   typedef struct {
      command_type             command;
      coord_type               start_x;
      coord_type               start_y;
      coord_type               end_x;
      coord_type               end_y;
      logic [ColorBits-1:0]    color;
   } line_request_type;

   // one point as expected on the rsp_ side
   typedef struct {
      coord_type               x;
      coord_type               y;
      logic [ColorBits-1:0]    color;
      logic                    inside_flag;
      logic                    last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CoordBits-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = 1'b0;
   logic signed [CoordBits-1:0] req_start_x = '0;
   logic signed [CoordBits-1:0] req_start_y = '0;
   logic signed [CoordBits-1:0] req_end_x = '0;
   logic signed [CoordBits-1:0] req_end_y = '0;
   logic [ColorBits-1:0] req_color_tag = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [CoordBits-1:0] rsp_pixel_x;
   logic signed [CoordBits-1:0] rsp_pixel_y;
   logic [ColorBits-1:0] rsp_pixel_color;
   logic rsp_inside_res;
   logic rsp_last;

   // walker copy kept in step with the block
   coord_type walk_cx, walk_cy, walk_tx, walk_ty;
   logic [CoordBits:0] walk_span_x;
   logic signed [CoordBits+1:0] walk_span_y;
   logic walk_x_neg, walk_y_neg;
   logic signed [ErrBits-1:0] walk_error;
   logic walk_active;
   logic [ColorBits-1:0] walk_color;
   coord_type clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;

   pixel_type pending_pixels[$];
   int pixels_requested = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   logic gaps_enabled = 1'b1;
   int hold_off_ticket = 0;
   int hold_off_served = 0;
   int hold_left = 0;
   int stall_left = 0;
   int run_left = 0;

   clipped_line_rasterizer_unit dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .req_color_tag(req_color_tag),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_inside_res(rsp_inside_res),
      .rsp_last(rsp_last)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // idle lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   // coordinate within spread of centre, held to the coordinate range
   function automatic coord_type near(coord_type centre, int spread);
      int v;
      v = int'(centre) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < int'(CoordMin)) v = int'(CoordMin);
      if (v > int'(ClipMax)) v = int'(ClipMax);
      return coord_type'(v);
   endfunction

   function automatic void reset_walker();
      walk_cx = '0;
      walk_cy = '0;
      walk_tx = '0;
      walk_ty = '0;
      walk_span_x = '0;
      walk_span_y = '0;
      walk_x_neg = 1'b0;
      walk_y_neg = 1'b0;
      walk_error = '0;
      walk_active = 1'b0;
      walk_color = '0;
      clip_left_q = '0;
      clip_top_q = '0;
      clip_right_q = ClipMax;
      clip_bottom_q = ClipMax;
   endfunction

   // set up spans, directions and error for a new line
   function automatic void load_line(line_request_type req);
      int dx, dy;
      dx = int'(req.end_x) - int'(req.start_x);
      dy = int'(req.end_y) - int'(req.start_y);
      walk_cx = req.start_x;
      walk_cy = req.start_y;
      walk_tx = req.end_x;
      walk_ty = req.end_y;
      walk_color = req.color;
      if (dx < 0) dx = -dx;
      if (dy > 0) dy = -dy;
      walk_span_x = (CoordBits+1)'(dx);
      walk_span_y = (CoordBits+2)'(dy);
      walk_x_neg = !(req.start_x < req.end_x);
      walk_y_neg = !(req.start_y < req.end_y);
      walk_error = ErrBits'(dx + dy);
      walk_active = 1'b1;
   endfunction

   // move the cursor one point on; 1 when the line has ended instead
   function automatic bit advance_cursor();
      int e2;
      if (walk_cx == walk_tx && walk_cy == walk_ty) return 1'b1;
      e2 = 2 * int'(walk_error);
      if (e2 >= int'(walk_span_y)) begin
         if (walk_cx == walk_tx) return 1'b1;
         walk_error = ErrBits'(int'(walk_error) + int'(walk_span_y));
         walk_cx = coord_type'(int'(walk_cx) + (walk_x_neg ? -1 : 1));
      end
      if (e2 <= int'(walk_span_x)) begin
         if (walk_cy == walk_ty) return 1'b1;
         walk_error = ErrBits'(int'(walk_error) + int'(walk_span_x));
         walk_cy = coord_type'(int'(walk_cy) + (walk_y_neg ? -1 : 1));
      end
      return 1'b0;
   endfunction

   // point caused by one accepted request; 0 when none comes back
   function automatic bit predict_pixel(line_request_type req, output pixel_type px);
      px = '{default: '0};
      if (req.command == CmdStart) load_line(req);
      else if (!walk_active) return 1'b0;
      px.x = walk_cx;
      px.y = walk_cy;
      px.color = walk_color;
      px.inside_flag = walk_cx >= clip_left_q && walk_cx < clip_right_q &&
                       walk_cy >= clip_top_q && walk_cy < clip_bottom_q;
      px.last = advance_cursor();
      walk_active = !px.last;
      return 1'b1;
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // result side: compare each transfer, then choose the next stall
   always @(posedge clock) begin : pixel_sink
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected point, expected none, actual x %0d y %0d",
                     $time, rsp_pixel_x, rsp_pixel_y);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_x", want.x, rsp_pixel_x);
            check_field("pixel_y", want.y, rsp_pixel_y);
            check_field("pixel_color", want.color, rsp_pixel_color);
            check_field("inside_res", want.inside_flag, rsp_inside_res);
            check_field("last", want.last, rsp_last);
         end
      end
      if (hold_off_ticket != hold_off_served) begin
         hold_off_served = hold_off_ticket;
         hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!gaps_enabled) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && run_left == 0) begin
            stall_left = pick_gap();
            run_left = $urandom_range(0, 6);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (run_left > 0) run_left--;
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one request and wait for its transfer
   task automatic send_request(command_type cmd, coord_type sx, coord_type sy,
                               coord_type ex, coord_type ey,
                               logic [ColorBits-1:0] color);
      line_request_type req;
      pixel_type px;
      int gap;
      gap = gaps_enabled ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      req_color_tag <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req.command = cmd;
      req.start_x = sx;
      req.start_y = sy;
      req.end_x = ex;
      req.end_y = ey;
      req.color = color;
      if (predict_pixel(req, px)) begin
         pending_pixels.push_back(px);
         pixels_requested++;
      end
   endtask

   // advance with junk in the unused fields
   task automatic send_advance();
      send_request(CmdAdvance, coord_type'($urandom), coord_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom), ColorBits'($urandom));
   endtask

   // start a line and advance until it ends or max_points have been asked for
   task automatic trace_line(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                             logic [ColorBits-1:0] color, int max_points);
      int points;
      send_request(CmdStart, sx, sy, ex, ey, color);
      points = 1;
      while (walk_active && points < max_points) begin
         send_advance();
         points++;
      end
   endtask

   // lower valid, wait for every expected point, then let the block settle
   task automatic wait_for_pixels();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_clip(logic [CsrIndexBits-1:0] index, coord_type value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      case (index)
         CsrClipLeft:   clip_left_q = value;
         CsrClipTop:    clip_top_q = value;
         CsrClipRight:  clip_right_q = value;
         CsrClipBottom: clip_bottom_q = value;
         default: ;
      endcase
   endtask

   // new clip rectangle, preceded by a write to an unmapped index
   task automatic set_clip_rect(coord_type left, coord_type top, coord_type right,
                                coord_type bottom);
      logic [CsrIndexBits-1:0] spare_index;
      spare_index = CsrIndexBits'(CsrClipBottom + 1 + $urandom_range(0, 3));
      write_clip(spare_index, coord_type'($urandom));
      write_clip(CsrClipLeft, left);
      write_clip(CsrClipTop, top);
      write_clip(CsrClipRight, right);
      write_clip(CsrClipBottom, bottom);
      csr_write_enable <= 1'b0;
   endtask

   // one random sequence around a centre: mostly whole short lines
   task automatic random_line(coord_type cx, coord_type cy, int spread);
      int kind;
      coord_type sx, sy;
      kind = $urandom_range(0, 99);
      sx = near(cx, spread);
      sy = near(cy, spread);
      if (kind < 70) begin
         trace_line(sx, sy, near(sx, $urandom_range(0, 7)), near(sy, $urandom_range(0, 7)),
                    ColorBits'($urandom), 64);
         if ($urandom_range(0, 9) == 0) send_advance();
      end else if (kind < 85) begin
         trace_line(coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                    coord_type'($urandom), ColorBits'($urandom), $urandom_range(1, 25));
      end else if (kind < 93) begin
         send_advance();
      end else begin
         send_request(command_type'($urandom_range(0, 1)), coord_type'($urandom),
                      coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                      ColorBits'($urandom));
      end
   endtask

   // idle advances, single point, octants, extremes and restart over a live line
   task automatic test_directed_lines();
      send_advance();
      trace_line(CoordMin, ClipMax, CoordMin, ClipMax, {ColorBits{1'b1}}, 4);
      send_advance();
      trace_line(0, 0, 3, 1, '0, 8);
      trace_line(2, -1, -1, -3, 8'h5a, 8);
      trace_line(CoordMin, CoordMin, ClipMax, ClipMax, 8'ha5, 3);
      trace_line(ClipMax, 0, coord_type'(ClipMax - 1), 3, 8'h3c, 8);
      wait_for_pixels();
   endtask

   // lines across the edges of several clip rectangles, empty ones included
   task automatic test_clip_rectangles();
      coord_type corner_x, corner_y;
      for (int setting = 0; setting < 6; setting++) begin
         case (setting)
            0: set_clip_rect(CoordMin, CoordMin, ClipMax, ClipMax);
            1: set_clip_rect(5, -10, 5, 10);
            2: set_clip_rect(-20, 100, 20, -100);
            3: begin
               corner_x = near(coord_type'($urandom), 0);
               corner_y = near(coord_type'($urandom), 0);
               set_clip_rect(corner_x, corner_y, coord_type'(near(corner_x, 0) + 1),
                             coord_type'(near(corner_y, 0) + 1));
            end
            4: set_clip_rect(ClipMax, ClipMax, CoordMin, CoordMin);
            default: set_clip_rect(-8, -8, 8, 8);
         endcase
         for (int n = 0; n < ClipLines; n++) begin
            corner_x = $urandom_range(0, 1) ? clip_left_q : clip_right_q;
            corner_y = $urandom_range(0, 1) ? clip_top_q : clip_bottom_q;
            random_line(corner_x, corner_y, 3);
         end
         wait_for_pixels();
      end
   endtask

   // receiver holds off while a long line keeps coming, then the sender waits it out
   task automatic test_back_pressure();
      gaps_enabled <= 1'b0;
      hold_off_ticket <= hold_off_ticket + 1;
      trace_line(-1000, 5, 1000, 40, 8'h77, 80);
      wait_for_pixels();
      trace_line(30, -30, -30, 30, 8'h81, 40);
      gaps_enabled <= 1'b1;
      wait_for_pixels();
   endtask

   // bulk random lines, fresh clip rectangle and idling mode now and then
   task automatic test_random_lines();
      int goal, next_reclip;
      coord_type a, b, c, d, cx, cy;
      goal = pixels_requested + RandomPoints;
      next_reclip = pixels_requested;
      while (pixels_requested < goal) begin
         if (pixels_requested >= next_reclip) begin
            wait_for_pixels();
            a = coord_type'($urandom);
            b = coord_type'($urandom);
            c = coord_type'($urandom);
            d = coord_type'($urandom);
            if ($urandom_range(0, 4) == 0) set_clip_rect(a, b, c, d);
            else set_clip_rect(a < c ? a : c, b < d ? b : d, a < c ? c : a, b < d ? d : b);
            gaps_enabled <= ($urandom_range(0, 3) != 0);
            next_reclip = pixels_requested + ReclipPoints;
         end
         if ($urandom_range(0, 1)) begin
            cx = coord_type'($urandom);
            cy = coord_type'($urandom);
         end else begin
            cx = $urandom_range(0, 1) ? clip_left_q : clip_right_q;
            cy = $urandom_range(0, 1) ? clip_top_q : clip_bottom_q;
         end
         random_line(cx, cy, 6);
      end
      gaps_enabled <= 1'b1;
   endtask

   initial begin
      reset_walker();
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_lines();
      test_clip_rectangles();
      test_back_pressure();
      test_random_lines();
      wait_for_pixels();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
